### rtl/jump_search_sorted_table_assert.svh
// Assertion macros shared by the jump search RTL modules.
`ifndef JUMP_SEARCH_SORTED_TABLE_ASSERT_SVH
`define JUMP_SEARCH_SORTED_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jss assertion failed");
`define JSS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("jss forbidden condition seen");
`else
`define JSS_ASSERT(lbl, prop)
`define JSS_NEVER(lbl, cond)
`endif
`endif

### rtl/jss_pkg.sv
// Shared widths, codes and controller/datapath interface types.
`default_nettype none
package jss_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CFG_W           = 9;
    localparam int IDX_W           = 8;
    localparam int VAL_W           = 32;
    localparam int IN_DW           = 72;
    localparam int OUT_DW          = 48;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic load_we;
        logic start;
        logic sqrt_step;
        logic jump;
        logic scan_init;
        logic scan_next;
        logic emit_jump;
        logic emit_scan;
        logic addr_scan;
    } jss_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic can_jump;
        logic scan_last;
        logic out_free;
    } jss_sts_t;

endpackage
`default_nettype wire

### rtl/jump_search_sorted_table.sv
// Top level of the jump search over a sorted table of signed values.
// Load item: written at the edge that accepts it, no result.
// Search item: an accept, root steps until root = floor(sqrt(size)), then a read and a compare
//   for entry 0, each jump target and each scanned entry, plus output stalls.
// Ready again the cycle after the final result is registered; one item in flight at a time.
// Reset (rst_n low, asynchronous) sets table_size to 1; table contents stay undefined.
`default_nettype none
module jump_search_sorted_table
    import jss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,    // table_size
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,     // load_index, load_value, search_key
    input  wire logic              s_tuser,     // kind
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,     // checked_index, checked_value, found, zeros
    output logic                   m_tlast      // last_check
);

    jss_cmd_t         cmd;
    jss_sts_t         sts;
    logic [IDX_W-1:0] checked_index;
    logic [VAL_W-1:0] checked_value;
    logic             found;

    assign cfg_ready = 1'b1;

    jss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    jss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .load_index    (s_tdata[IDX_W-1:0]),
        .load_value    (s_tdata[IDX_W+VAL_W-1:IDX_W]),
        .search_key    (s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .checked_index (checked_index),
        .checked_value (checked_value),
        .found         (found),
        .last_check    (m_tlast)
    );

    assign m_tdata = {(OUT_DW - IDX_W - VAL_W - 1)'(0), found, checked_value, checked_index};

endmodule
`default_nettype wire

### rtl/jss_ctrl.sv
// Sequencer for load and jump search items.
`default_nettype none
`include "jump_search_sorted_table_assert.svh"
module jss_ctrl
    import jss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic     s_tuser,
    output jss_cmd_t      cmd,
    input  wire jss_sts_t sts
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQRT   = 6'b000010,
        ST_J_RD   = 6'b000100,
        ST_J_EVAL = 6'b001000,
        ST_S_RD   = 6'b010000,
        ST_S_EVAL = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   jumped_reg, jumped_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        jumped_next = jumped_reg;
        cmd         = '0;
        cmd.addr_scan = (state_reg == ST_S_RD) || (state_reg == ST_S_EVAL);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == KIND_SEARCH)
                    begin
                        cmd.start   = 1'b1;
                        jumped_next = 1'b0;
                        state_next  = ST_SQRT;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                    state_next = ST_J_RD;
                else
                    cmd.sqrt_step = 1'b1;
            end
            ST_J_RD:
            begin
                state_next = ST_J_EVAL;
            end
            ST_J_EVAL:
            begin
                // a jump target is reported in the same cycle as the next decision
                if (!jumped_reg || sts.out_free)
                begin
                    cmd.emit_jump = jumped_reg;
                    if (sts.can_jump)
                    begin
                        cmd.jump    = 1'b1;
                        jumped_next = 1'b1;
                        state_next  = ST_J_RD;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_S_RD;
                    end
                end
            end
            ST_S_RD:
            begin
                state_next = ST_S_EVAL;
            end
            ST_S_EVAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_scan = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = ST_S_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            jumped_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            jumped_reg <= jumped_next;
        end
    end

    `JSS_ASSERT(a_search_starts_sqrt,
        (state_reg == ST_IDLE && s_tvalid && s_tuser == KIND_SEARCH) |=> state_reg == ST_SQRT)
    `JSS_ASSERT(a_emit_needs_room, (cmd.emit_jump || cmd.emit_scan) |-> sts.out_free)
    `JSS_NEVER(a_single_emit, cmd.emit_jump && cmd.emit_scan)
    `JSS_ASSERT(a_final_returns_idle,
        (state_reg == ST_S_EVAL && sts.out_free && sts.scan_last) |=> state_reg == ST_IDLE)

endmodule
`default_nettype wire

### rtl/jss_datapath.sv
// Table memory, square root, jump and scan registers, and the result register.
`default_nettype none
`include "jump_search_sorted_table_assert.svh"
module jss_datapath
    import jss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic [IDX_W-1:0] load_index,
    input  wire logic [VAL_W-1:0] load_value,
    input  wire logic [VAL_W-1:0] search_key,
    input  wire jss_cmd_t         cmd,
    output jss_sts_t              sts,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [IDX_W-1:0]      checked_index,
    output logic [VAL_W-1:0]      checked_value,
    output logic                  found,
    output logic                  last_check
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int QW = SW + 2;

    logic [VAL_W-1:0] mem [TABLE_DEPTH];
    logic [VAL_W-1:0] rdata_reg;
    logic [VAL_W-1:0] key_reg;
    logic [CFG_W-1:0] table_size_reg;
    logic [SW-1:0]    size_reg, size_next, size_eff;
    logic [SW-1:0]    root_reg, root_next;
    logic [QW-1:0]    sq_reg, sq_next;
    logic [AW-1:0]    cur_reg, cur_next, prev_reg, prev_next, i_reg, i_next;
    logic [AW-1:0]    rd_addr;
    logic [SW:0]      jump_sum;
    logic [SW-1:0]    last_idx;
    logic             load_ok, hit;
    logic             out_valid_reg, out_valid_next;

    // Clamp the register to the range the table supports.
    always_comb
    begin
        priority if (table_size_reg == '0)
            size_eff = SW'(1);
        else if (int'(table_size_reg) > TABLE_DEPTH)
            size_eff = SW'(TABLE_DEPTH);
        else
            size_eff = SW'(table_size_reg);
    end

    assign load_ok  = int'(load_index) < TABLE_DEPTH;
    assign rd_addr  = cmd.addr_scan ? i_reg : cur_reg;
    assign last_idx = size_reg - SW'(1);
    assign jump_sum = (SW + 1)'(cur_reg) + (SW + 1)'(root_reg);
    assign hit      = (rdata_reg == key_reg);

    assign sts.sqrt_done = sq_reg > QW'(size_reg);
    assign sts.can_jump  = ((SW + 1)'(cur_reg) + (SW + 1)'(1) < (SW + 1)'(size_reg))
                           && ($signed(rdata_reg) < $signed(key_reg));
    assign sts.scan_last = hit || (i_reg == cur_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        size_next = size_reg;
        root_next = root_reg;
        sq_next   = sq_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        i_next    = i_reg;
        if (cmd.start)
        begin
            size_next = size_eff;
            root_next = '0;
            sq_next   = QW'(1);
            cur_next  = '0;
            prev_next = '0;
            i_next    = '0;
        end
        if (cmd.sqrt_step)
        begin
            // (r+2)^2 = (r+1)^2 + 2r + 3
            root_next = root_reg + SW'(1);
            sq_next   = sq_reg + QW'({root_reg, 1'b0}) + QW'(3);
        end
        if (cmd.jump)
        begin
            prev_next = cur_reg;
            if (jump_sum > (SW + 1)'(last_idx))
                cur_next = AW'(last_idx);
            else
                cur_next = AW'(jump_sum);
        end
        if (cmd.scan_init)
            i_next = prev_reg;
        if (cmd.scan_next)
            i_next = i_reg + AW'(1);
    end

    always_comb
    begin
        if (cmd.emit_jump || cmd.emit_scan)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && load_ok)
            mem[AW'(load_index)] <= load_value;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            key_reg <= search_key;
        if (cmd.emit_jump)
        begin
            checked_index <= IDX_W'(cur_reg);
            checked_value <= rdata_reg;
            found         <= 1'b0;
            last_check    <= 1'b0;
        end
        else if (cmd.emit_scan)
        begin
            checked_index <= IDX_W'(i_reg);
            checked_value <= rdata_reg;
            found         <= hit;
            last_check    <= sts.scan_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= CFG_W'(1);
            size_reg       <= SW'(1);
            root_reg       <= '0;
            sq_reg         <= QW'(1);
            cur_reg        <= '0;
            prev_reg       <= '0;
            i_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                table_size_reg <= cfg_data;
            size_reg      <= size_next;
            root_reg      <= root_next;
            sq_reg        <= sq_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `JSS_ASSERT(a_cur_in_table, (SW + 1)'(cur_reg) < (SW + 1)'(size_reg))
    `JSS_ASSERT(a_prev_not_past_cur, prev_reg <= cur_reg)
    `JSS_ASSERT(a_scan_not_past_cur, i_reg <= cur_reg)

endmodule
`default_nettype wire
